// ===== src/qoi_pkg.sv =====
`default_nettype none
package qoi_pkg;

    localparam logic [1:0] KIND_INTEGRATE = 2'd0;
    localparam logic [1:0] KIND_NORMALIZE = 2'd1;
    localparam logic [1:0] KIND_LOAD      = 2'd2;

    localparam logic [1:0] RATE_X = 2'd0;
    localparam logic [1:0] RATE_Y = 2'd1;
    localparam logic [1:0] RATE_Z = 2'd2;

    localparam logic [1:0] COMP_R = 2'd0;
    localparam logic [1:0] COMP_I = 2'd1;
    localparam logic [1:0] COMP_J = 2'd2;
    localparam logic [1:0] COMP_K = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_LOAD, ST_MAC, ST_SCALE, ST_ADD, ST_COMMIT,
        ST_SQ, ST_CHK, ST_SQRT, ST_DINIT, ST_DIV, ST_DWR, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAPTURE, DP_LOAD, DP_MAC, DP_SCALE, DP_ADD, DP_COMMIT,
        DP_SQ, DP_CHK, DP_SQRT, DP_DINIT, DP_DIV, DP_DWR, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
        logic [1:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       norm_zero;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] rate_sel;
        logic [1:0] q_sel;
        logic       neg;
    } mac_term_t;

    // terms of w * q, w = (0, x, y, z) on the left
    function automatic mac_term_t mac_term(input logic [1:0] comp, input logic [1:0] term);
        mac_term_t t;
        t = '{rate_sel: RATE_X, q_sel: COMP_R, neg: 1'b0};
        case ({comp, term})
            {COMP_R, 2'd0}: t = '{rate_sel: RATE_X, q_sel: COMP_I, neg: 1'b1};
            {COMP_R, 2'd1}: t = '{rate_sel: RATE_Y, q_sel: COMP_J, neg: 1'b1};
            {COMP_R, 2'd2}: t = '{rate_sel: RATE_Z, q_sel: COMP_K, neg: 1'b1};
            {COMP_I, 2'd0}: t = '{rate_sel: RATE_X, q_sel: COMP_R, neg: 1'b0};
            {COMP_I, 2'd1}: t = '{rate_sel: RATE_Y, q_sel: COMP_K, neg: 1'b0};
            {COMP_I, 2'd2}: t = '{rate_sel: RATE_Z, q_sel: COMP_J, neg: 1'b1};
            {COMP_J, 2'd0}: t = '{rate_sel: RATE_Y, q_sel: COMP_R, neg: 1'b0};
            {COMP_J, 2'd1}: t = '{rate_sel: RATE_Z, q_sel: COMP_I, neg: 1'b0};
            {COMP_J, 2'd2}: t = '{rate_sel: RATE_X, q_sel: COMP_K, neg: 1'b1};
            {COMP_K, 2'd0}: t = '{rate_sel: RATE_Z, q_sel: COMP_R, neg: 1'b0};
            {COMP_K, 2'd1}: t = '{rate_sel: RATE_X, q_sel: COMP_J, neg: 1'b0};
            {COMP_K, 2'd2}: t = '{rate_sel: RATE_Y, q_sel: COMP_I, neg: 1'b1};
            default:        t = '{rate_sel: RATE_X, q_sel: COMP_R, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== src/qoi_datapath.sv =====
`default_nettype none
module qoi_datapath #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire qoi_pkg::dp_cmd_t   cmd,
    output qoi_pkg::dp_status_t     status,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [15:0] s_rate_x,
    input  wire logic signed [15:0] s_rate_y,
    input  wire logic signed [15:0] s_rate_z,
    input  wire logic [15:0]        s_time_step,
    input  wire logic signed [15:0] s_load_real,
    input  wire logic signed [15:0] s_load_first,
    input  wire logic signed [15:0] s_load_second,
    input  wire logic signed [15:0] s_load_third,
    output logic signed [15:0]      m_out_real,
    output logic signed [15:0]      m_out_first,
    output logic signed [15:0]      m_out_second,
    output logic signed [15:0]      m_out_third
);
    import qoi_pkg::*;

    localparam int W    = COMPONENT_WIDTH;
    localparam int FRAC = W - 2;
    localparam int AW   = W + 18;
    localparam int MW   = AW + 16;
    localparam int SW   = MW + 2;
    localparam int QW   = 2 * W + 2;
    localparam int DW   = 2 * W;
    localparam int LSH  = (W >= 16) ? W - 16 : 0;
    localparam int RSH  = (W < 16) ? 16 - W : 0;

    localparam logic signed [W-1:0]  HI_W  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  LO_W  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  ONE_W = W'(1) << FRAC;
    localparam logic [W-1:0]         CAP   = {1'b0, {(W-1){1'b1}}};
    localparam logic [MW-1:0]        HALF  = MW'(1) << 24;
    localparam logic signed [SW-1:0] HI_S  = SW'(HI_W);
    localparam logic signed [SW-1:0] LO_S  = SW'(LO_W);

    logic signed [W-1:0]  q_reg [4];
    logic signed [W-1:0]  nq_reg [4];
    logic [1:0]           kind_reg;
    logic signed [15:0]   rate_reg [3];
    logic [15:0]          dt_reg;
    logic signed [15:0]   ld_reg [4];
    logic signed [AW-1:0] acc_reg;
    logic [MW-1:0]        m_reg;
    logic [QW-1:0]        sum_reg;
    logic [QW-1:0]        x_reg;
    logic [QW-1:0]        res_reg;
    logic [QW-1:0]        bit_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        dv_reg;
    logic [W-2:0]         quo_reg;
    logic                 ovf_reg;
    logic signed [15:0]   out_reg [4];

    mac_term_t            mt;
    logic signed [W+15:0] prod;
    logic [AW-1:0]        acc_mag;
    logic [MW-1:0]        scaled;
    logic [MW-1:0]        inc;
    logic signed [SW-1:0] inc_s;
    logic signed [SW-1:0] qsum;
    logic signed [W-1:0]  qsat;
    logic signed [W-1:0]  qsel;
    logic [W-1:0]         qmag;
    logic [W-1:0]         qcap;
    logic [DW-1:0]        sq;
    logic [QW-1:0]        trial;
    logic [W-1:0]         nrm;
    logic [DW-1:0]        dividend;
    logic signed [W-1:0]  qdiv;
    logic signed [W+15:0] ld_ext [4];
    logic signed [W+15:0] q_ext [4];

    always_comb begin
        mt      = mac_term(cmd.comp, cmd.term);
        prod    = rate_reg[mt.rate_sel] * q_reg[mt.q_sel];
        acc_mag = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        scaled  = MW'(acc_mag) * MW'(dt_reg);
        inc     = (m_reg + HALF) >> 25;
        inc_s   = $signed({2'b00, inc});
        qsel    = q_reg[cmd.comp];
        qsum    = SW'(qsel) + (acc_reg[AW-1] ? -inc_s : inc_s);
        if (qsum > HI_S) begin
            qsat = HI_W;
        end else if (qsum < LO_S) begin
            qsat = LO_W;
        end else begin
            qsat = W'(qsum);
        end
        qmag     = qsel[W-1] ? W'(-qsel) : W'(qsel);
        qcap     = (qmag > CAP) ? CAP : qmag;
        sq       = DW'(qcap) * DW'(qcap);
        trial    = res_reg + bit_reg;
        nrm      = res_reg[W-1:0];
        dividend = DW'(qmag) << FRAC;
        if (ovf_reg) begin
            qdiv = qsel[W-1] ? LO_W : HI_W;
        end else begin
            qdiv = qsel[W-1] ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        end
        for (int n = 0; n < 4; n++) begin
            ld_ext[n] = (W+16)'(ld_reg[n]);
            q_ext[n]  = (W+16)'(q_reg[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= ONE_W;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end else begin
            case (cmd.op)
                DP_CAPTURE: begin
                    kind_reg    <= s_kind;
                    rate_reg[0] <= s_rate_x;
                    rate_reg[1] <= s_rate_y;
                    rate_reg[2] <= s_rate_z;
                    dt_reg      <= s_time_step;
                    ld_reg[0]   <= s_load_real;
                    ld_reg[1]   <= s_load_first;
                    ld_reg[2]   <= s_load_second;
                    ld_reg[3]   <= s_load_third;
                    acc_reg     <= '0;
                    sum_reg     <= '0;
                end
                DP_LOAD: begin
                    for (int n = 0; n < 4; n++) begin
                        q_reg[n] <= W'((ld_ext[n] <<< LSH) >>> RSH);
                    end
                end
                DP_MAC: begin
                    acc_reg <= mt.neg ? acc_reg - AW'(prod) : acc_reg + AW'(prod);
                end
                DP_SCALE: m_reg <= scaled;
                DP_ADD: begin
                    nq_reg[cmd.comp] <= qsat;
                    acc_reg          <= '0;
                end
                DP_COMMIT: begin
                    for (int n = 0; n < 4; n++) begin
                        q_reg[n] <= nq_reg[n];
                    end
                end
                DP_SQ: sum_reg <= sum_reg + QW'(sq);
                DP_CHK: begin
                    if (sum_reg == '0) begin
                        q_reg[0] <= ONE_W;
                    end
                    x_reg   <= sum_reg;
                    res_reg <= '0;
                    bit_reg <= QW'(1) << (2 * W - 2);
                end
                DP_SQRT: begin
                    if (x_reg >= trial) begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                DP_DINIT: begin
                    rem_reg <= dividend;
                    dv_reg  <= DW'(nrm) << (W - 2);
                    ovf_reg <= dividend >= (DW'(nrm) << (W - 1));
                    quo_reg <= '0;
                end
                DP_DIV: begin
                    if (rem_reg >= dv_reg) begin
                        rem_reg <= rem_reg - dv_reg;
                        quo_reg <= {quo_reg[W-3:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[W-3:0], 1'b0};
                    end
                    dv_reg <= dv_reg >> 1;
                end
                DP_DWR: q_reg[cmd.comp] <= qdiv;
                DP_OUT: begin
                    for (int n = 0; n < 4; n++) begin
                        out_reg[n] <= 16'((q_ext[n] <<< RSH) >>> LSH);
                    end
                end
                default: ;
            endcase
        end
    end

    assign status.kind      = kind_reg;
    assign status.norm_zero = (sum_reg == '0);

    assign m_out_real   = out_reg[0];
    assign m_out_first  = out_reg[1];
    assign m_out_second = out_reg[2];
    assign m_out_third  = out_reg[3];

endmodule
`default_nettype wire

// ===== src/qoi_controller.sv =====
`default_nettype none
module qoi_controller #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire qoi_pkg::dp_status_t status,
    output qoi_pkg::dp_cmd_t         cmd
);
    import qoi_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int CW = $clog2(W + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_START;
            ST_START: begin
                cnt_next  = '0;
                comp_next = COMP_R;
                case (status.kind)
                    KIND_INTEGRATE: state_next = ST_MAC;
                    KIND_NORMALIZE: state_next = ST_SQ;
                    KIND_LOAD:      state_next = ST_LOAD;
                    default:        state_next = ST_OUT;
                endcase
            end
            ST_LOAD: state_next = ST_OUT;
            ST_MAC: begin
                if (cnt_reg == CW'(2)) begin
                    state_next = ST_SCALE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCALE: state_next = ST_ADD;
            ST_ADD: begin
                cnt_next = '0;
                if (comp_reg == COMP_K) begin
                    state_next = ST_COMMIT;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_COMMIT: state_next = ST_OUT;
            ST_SQ: begin
                if (comp_reg == COMP_K) begin
                    state_next = ST_CHK;
                end else begin
                    comp_next = comp_reg + 1'b1;
                end
            end
            ST_CHK: begin
                cnt_next  = '0;
                comp_next = COMP_R;
                state_next = status.norm_zero ? ST_OUT : ST_SQRT;
            end
            ST_SQRT: begin
                if (cnt_reg == CW'(W - 1)) begin
                    state_next = ST_DINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT: begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == CW'(W - 2)) begin
                    state_next = ST_DWR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DWR: begin
                if (comp_reg == COMP_K) begin
                    state_next = ST_OUT;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_DINIT;
                end
            end
            ST_OUT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = DP_NOP;
        cmd.comp     = comp_reg;
        cmd.term     = cnt_reg[1:0];
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = DP_CAPTURE;
            end
            ST_LOAD:   cmd.op = DP_LOAD;
            ST_MAC:    cmd.op = DP_MAC;
            ST_SCALE:  cmd.op = DP_SCALE;
            ST_ADD:    cmd.op = DP_ADD;
            ST_COMMIT: cmd.op = DP_COMMIT;
            ST_SQ:     cmd.op = DP_SQ;
            ST_CHK:    cmd.op = DP_CHK;
            ST_SQRT:   cmd.op = DP_SQRT;
            ST_DINIT:  cmd.op = DP_DINIT;
            ST_DIV:    cmd.op = DP_DIV;
            ST_DWR:    cmd.op = DP_DWR;
            ST_OUT: begin
                if (out_free) begin
                    cmd.op       = DP_OUT;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= COMP_R;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            comp_reg    <= comp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== src/quaternion_orientation_integrator.sv =====
// quaternion orientation integrator
// holds one orientation quaternion (r, i, j, k), Q1.14 at the ports,
// COMPONENT_WIDTH bits with COMPONENT_WIDTH-2 fraction bits inside
// input channel s_*: valid/ready, one item per command, s_kind selects
//   integrate (0), normalize (1), load (2); kind 3 just reports q
// result channel m_*: valid/ready, exactly one item per input item,
//   carrying q as it stands after the update
// sequence per kind, W = COMPONENT_WIDTH:
//   load copies the load ports into q; integrate runs three MAC terms for
//   each of the four components, each followed by scale and add, then commits;
//   normalize sums four squares and, for nonzero norm, runs a W-step square
//   root and a bit-serial divide per component; zero norm gives identity
// throughput: one item at a time, next item accepted once the controller
//   is back in idle, which it enters as the result is registered
// reset: q returns to identity (one, 0, 0, 0), no result pending
// receiver stall: the result holds in the output register; a new item is
//   still accepted and worked on, and only its result waits for the slot
`default_nettype none
module quaternion_orientation_integrator #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [15:0] s_rate_x,
    input  wire logic signed [15:0] s_rate_y,
    input  wire logic signed [15:0] s_rate_z,
    input  wire logic [15:0]        s_time_step,
    input  wire logic signed [15:0] s_load_real,
    input  wire logic signed [15:0] s_load_first,
    input  wire logic signed [15:0] s_load_second,
    input  wire logic signed [15:0] s_load_third,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_real,
    output logic signed [15:0]      m_out_first,
    output logic signed [15:0]      m_out_second,
    output logic signed [15:0]      m_out_third
);
    import qoi_pkg::*;

    // command and status between sequencer and arithmetic
    dp_cmd_t    cmd;
    dp_status_t status;

    qoi_controller #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // quaternion state, MAC, square root and divider steps
    qoi_datapath #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_kind        (s_kind),
        .s_rate_x      (s_rate_x),
        .s_rate_y      (s_rate_y),
        .s_rate_z      (s_rate_z),
        .s_time_step   (s_time_step),
        .s_load_real   (s_load_real),
        .s_load_first  (s_load_first),
        .s_load_second (s_load_second),
        .s_load_third  (s_load_third),
        .m_out_real    (m_out_real),
        .m_out_first   (m_out_first),
        .m_out_second  (m_out_second),
        .m_out_third   (m_out_third)
    );

endmodule
`default_nettype wire

// ===== src/qoi_checker.sv =====
`default_nettype none
module qoi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_out_real,
    input wire logic [15:0] m_out_first,
    input wire logic [15:0] m_out_second,
    input wire logic [15:0] m_out_third
);

    // result stays offered until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("m_valid dropped before m_ready");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_out_real) && $stable(m_out_first)
            && $stable(m_out_second) && $stable(m_out_third)))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after accept");

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind quaternion_orientation_integrator qoi_checker u_qoi_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_real   (m_out_real),
    .m_out_first  (m_out_first),
    .m_out_second (m_out_second),
    .m_out_third  (m_out_third)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import qoi_pkg::*;

    localparam int  HALF_PERIOD = 5;
    localparam int  CYCLE_LIMIT = 900000;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  RANDOM_ITEMS = 1150;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic signed [15:0] s_rate_x = '0, s_rate_y = '0, s_rate_z = '0;
    logic [15:0] s_time_step = '0;
    logic signed [15:0] s_load_real = '0, s_load_first = '0;
    logic signed [15:0] s_load_second = '0, s_load_third = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_out_real, m_out_first, m_out_second, m_out_third;

    // one orientation as seen at the result port
    typedef struct packed {
        logic signed [15:0] r;
        logic signed [15:0] i;
        logic signed [15:0] j;
        logic signed [15:0] k;
    } quat_t;

    // predicted orientation state, default width so Q1.14 inside and out
    logic signed [15:0] attitude [4];
    quat_t pending_quats [$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    quaternion_orientation_integrator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_rate_x(s_rate_x), .s_rate_y(s_rate_y), .s_rate_z(s_rate_z),
        .s_time_step(s_time_step),
        .s_load_real(s_load_real), .s_load_first(s_load_first),
        .s_load_second(s_load_second), .s_load_third(s_load_third),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_real(m_out_real), .m_out_first(m_out_first),
        .m_out_second(m_out_second), .m_out_third(m_out_third)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // clamp to the 16 bit component range
    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // 0.5*dt*p with round half away from zero, p in 2^-22 units
    function automatic longint rate_increment(input longint p, input longint dt);
        longint m;
        longint d;
        m = (p < 0) ? -p : p;
        d = (m * dt + (64'sd1 <<< 24)) >>> 25;
        return (p < 0) ? -d : d;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // advance the predicted attitude by one item and return the port view
    function automatic quat_t advance_attitude(input logic [1:0] kind,
            input logic signed [15:0] wx, input logic signed [15:0] wy,
            input logic signed [15:0] wz, input logic [15:0] dt,
            input quat_t ld);
        longint r, i, j, k, a, b, c;
        longint p [4];
        longint unsigned sumsq, nrm, mg, qv;
        longint v;
        quat_t res;
        r = attitude[0]; i = attitude[1]; j = attitude[2]; k = attitude[3];
        a = wx; b = wy; c = wz;
        case (kind)
            KIND_INTEGRATE: begin
                // hamilton product w * q with w on the left
                p[0] = -(a * i + b * j + c * k);
                p[1] = a * r + b * k - c * j;
                p[2] = b * r + c * i - a * k;
                p[3] = c * r + a * j - b * i;
                for (int n = 0; n < 4; n++)
                    attitude[n] = clamp16(longint'(attitude[n])
                        + rate_increment(p[n], longint'(dt)));
            end
            KIND_NORMALIZE: begin
                // most negative value counts as 32767 in the sum of squares
                sumsq = 0;
                for (int n = 0; n < 4; n++) begin
                    mg = (attitude[n] < 0) ? -longint'(attitude[n]) : attitude[n];
                    if (mg > 32767) mg = 32767;
                    sumsq += mg * mg;
                end
                if (sumsq == 0) begin
                    // zero norm falls back to identity
                    attitude[0] = 16'sd16384;
                end else begin
                    nrm = int_sqrt(sumsq);
                    for (int n = 0; n < 4; n++) begin
                        mg = (attitude[n] < 0) ? -longint'(attitude[n]) : attitude[n];
                        qv = (mg << 14) / nrm;
                        v = longint'(qv);
                        attitude[n] = clamp16(attitude[n] < 0 ? -v : v);
                    end
                end
            end
            KIND_LOAD: begin
                attitude[0] = ld.r; attitude[1] = ld.i;
                attitude[2] = ld.j; attitude[3] = ld.k;
            end
            default: ;
        endcase
        res.r = attitude[0]; res.i = attitude[1];
        res.j = attitude[2]; res.k = attitude[3];
        return res;
    endfunction

    // send one item; prediction is made at the accepting edge
    task automatic send_item(input logic [1:0] kind, input logic signed [15:0] wx,
            input logic signed [15:0] wy, input logic signed [15:0] wz,
            input logic [15:0] dt, input quat_t ld);
        do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_rate_x <= wx; s_rate_y <= wy; s_rate_z <= wz;
        s_time_step <= dt;
        s_load_real <= ld.r; s_load_first <= ld.i;
        s_load_second <= ld.j; s_load_third <= ld.k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_quats.push_back(advance_attitude(kind, wx, wy, wz, dt, ld));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic quat_t rand_quat();
        quat_t q;
        q = {$urandom, $urandom};
        return q;
    endfunction

    // unit-ish orientation with small random perturbation
    function automatic quat_t near_unit_quat();
        quat_t q;
        q.r = 16'sd16384 - 16'($urandom_range(4000));
        q.i = $signed(16'($urandom_range(8000))) - 16'sd4000;
        q.j = $signed(16'($urandom_range(8000))) - 16'sd4000;
        q.k = $signed(16'($urandom_range(8000))) - 16'sd4000;
        return q;
    endfunction

    function automatic logic signed [15:0] rand_rate();
        // mostly modest rates, sometimes full range
        if ($urandom_range(9) == 0) return 16'($urandom);
        return $signed(16'($urandom_range(2048))) - 16'sd1024;
    endfunction

    task automatic test_directed_extremes();
        quat_t z;
        quat_t mx;
        quat_t mn;
        z = '0;
        mx = {4{16'sh7fff}};
        mn = {4{16'sh8000}};
        // unused kind reports reset identity
        send_item(KIND_UNUSED, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff, mx);
        send_item(KIND_INTEGRATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, mn);
        send_item(KIND_INTEGRATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff, mx);
        send_item(KIND_INTEGRATE, 16'sh0100, 16'sh0000, 16'sh0000, 16'h0000, z);
        send_item(KIND_NORMALIZE, '0, '0, '0, '0, z);
        // zero norm case
        send_item(KIND_LOAD, '0, '0, '0, '0, z);
        send_item(KIND_NORMALIZE, 16'sh7fff, 16'sh8000, '1, '1, mx);
        // most negative components in the norm
        send_item(KIND_LOAD, '0, '0, '0, '0, mn);
        send_item(KIND_NORMALIZE, '0, '0, '0, '0, z);
        send_item(KIND_LOAD, '0, '0, '0, '0, mx);
        send_item(KIND_NORMALIZE, '0, '0, '0, '0, z);
        send_item(KIND_LOAD, '0, '0, '0, '0, {16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000});
        send_item(KIND_NORMALIZE, '0, '0, '0, '0, z);
        // saturation of integration near full scale
        send_item(KIND_LOAD, '0, '0, '0, '0, {16'sh7ff0, 16'sh7ff0, 16'sh8010, 16'sh8010});
        send_item(KIND_INTEGRATE, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff, z);
        send_item(KIND_INTEGRATE, 16'sh0001, 16'shffff, 16'sh0001, 16'h0001, z);
        send_item(KIND_UNUSED, '0, '0, '0, '0, z);
    endtask

    task automatic test_random_items(input int count);
        int choice;
        for (int n = 0; n < count; n++) begin
            choice = $urandom_range(99);
            if (choice < 55)
                send_item(KIND_INTEGRATE, rand_rate(), rand_rate(), rand_rate(),
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000)),
                          rand_quat());
            else if (choice < 75)
                send_item(KIND_NORMALIZE, rand_rate(), rand_rate(), rand_rate(),
                          16'($urandom), rand_quat());
            else if (choice < 95)
                send_item(KIND_LOAD, rand_rate(), rand_rate(), rand_rate(), 16'($urandom),
                          ($urandom_range(1) == 0) ? near_unit_quat() : rand_quat());
            else
                send_item(KIND_UNUSED, rand_rate(), rand_rate(), rand_rate(), 16'($urandom),
                          rand_quat());
        end
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        quat_t exp_q;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_quats.size() == 0) begin
                $error("unexpected result item");
                fail_count++;
            end else begin
                exp_q = pending_quats.pop_front();
                if (m_out_real !== exp_q.r) begin
                    $error("out_real expected %0d actual %0d", exp_q.r, m_out_real);
                    fail_count++;
                end
                if (m_out_first !== exp_q.i) begin
                    $error("out_first expected %0d actual %0d", exp_q.i, m_out_first);
                    fail_count++;
                end
                if (m_out_second !== exp_q.j) begin
                    $error("out_second expected %0d actual %0d", exp_q.j, m_out_second);
                    fail_count++;
                end
                if (m_out_third !== exp_q.k) begin
                    $error("out_third expected %0d actual %0d", exp_q.k, m_out_third);
                    fail_count++;
                end
            end
        end
    end

    // timeout watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quaternion_orientation_integrator test failed");
            $finish;
        end
    end

    initial begin
        attitude[0] = 16'sd16384;
        attitude[1] = '0; attitude[2] = '0; attitude[3] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        // sender idles lightly, receiver stalls often
        send_idle_pct = 20; recv_idle_pct = 55;
        test_random_items(RANDOM_ITEMS / 3);
        send_idle_pct = 55; recv_idle_pct = 20;
        test_random_items(RANDOM_ITEMS / 3);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        // drain
        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("quaternion_orientation_integrator test passed");
        else
            $display("quaternion_orientation_integrator test failed");
        $finish;
    end
endmodule
`default_nettype wire
